// ===== rtl/core/vrt_pkg.sv =====
// Shared types and constants of the voxel ray traversal shader.
`timescale 1ns / 1ps
package vrt_pkg;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int COORD_W     = 4;
    localparam int DIR_W       = 16;
    localparam int FRAC_W      = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 2'd2;

    localparam logic [15:0] ORIGIN_X_RST = 16'h8000;
    localparam logic [15:0] ORIGIN_Y_RST = 16'hA000;
    localparam logic [15:0] ORIGIN_Z_RST = 16'h8000;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TRACE = 1'b1;

    localparam logic [2:0] NRM_XLO = 3'd0;
    localparam logic [2:0] NRM_XHI = 3'd1;
    localparam logic [2:0] NRM_YLO = 3'd2;
    localparam logic [2:0] NRM_YHI = 3'd3;
    localparam logic [2:0] NRM_ZLO = 3'd4;
    localparam logic [2:0] NRM_ZHI = 3'd5;

    localparam logic [1:0] KIND_DIRT       = 2'd0;
    localparam logic [1:0] KIND_GRASS_TOP  = 2'd1;
    localparam logic [1:0] KIND_GRASS_SIDE = 2'd2;

    localparam logic [1:0] VSEL_TRACE = 2'd0;
    localparam logic [1:0] VSEL_SCAN  = 2'd1;
    localparam logic [1:0] VSEL_TEX   = 2'd2;

    typedef struct packed {
        logic       load_item;
        logic       clr_step;
        logic       vox_wr;
        logic       col_wr_y;
        logic       col_wr_h;
        logic       scan_init;
        logic       scan_dec;
        logic [1:0] vox_rsel;
        logic       col_nb;
        logic       trace_init;
        logic       step;
        logic       origin_frac;
        logic       mul_ax;
        logic       div_start;
        logic       acc_ax;
        logic       fin;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic wr_in_grid;
        logic solid_in;
        logic vox_q;
        logic h_lt_y;
        logic h_ge_y;
        logic scan_go;
        logic cell_in_grid;
        logic dir_zero;
        logic has_last;
        logic div_busy;
        logic div_done;
        logic ax_last;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/vrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module vrt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/vrt_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module vrt_div #(
    parameter int DENW = 16,
    parameter int QUOW = 17
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DENW+QUOW-1:0] i_num,
    input  logic [DENW-1:0]      i_den,
    output logic                 o_busy,
    output logic                 o_done,
    output logic [QUOW-1:0]      o_quo,
    output logic                 o_rem_nz
);
    localparam int CNTW = $clog2(QUOW + 1);

    logic [DENW-1:0] r_rem, n_rem;
    logic [QUOW-1:0] r_sh;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy, r_done;
    logic [DENW:0]   w_t;
    logic            w_ge;

    always_comb begin
        w_t   = {r_rem, r_sh[QUOW-1]};
        w_ge  = (w_t >= {1'b0, i_den});
        n_rem = w_ge ? DENW'(w_t - {1'b0, i_den}) : w_t[DENW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[DENW+QUOW-1:QUOW];
            r_sh  <= i_num[QUOW-1:0];
            r_cnt <= CNTW'(QUOW);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_sh  <= {r_sh[QUOW-2:0], w_ge};
            r_cnt <= r_cnt - CNTW'(1);
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_quo    = r_sh;
    assign o_rem_nz = |r_rem;
endmodule

// ===== rtl/core/vrt_ctrl.sv =====
// Control state machine: grid clear, voxel write, column rescan, ray walk, hit shading.
`timescale 1ns / 1ps
module vrt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_mode,
    input  vrt_pkg::t_sts i_sts,
    output logic          o_s_tready,
    output vrt_pkg::t_cmd o_cmd
);
    import vrt_pkg::*;

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_W_WR   = 4'd2;
    localparam logic [3:0] S_W_HCHK = 4'd3;
    localparam logic [3:0] S_W_SRD  = 4'd4;
    localparam logic [3:0] S_W_SCHK = 4'd5;
    localparam logic [3:0] S_T_INIT = 4'd6;
    localparam logic [3:0] S_T_RD   = 4'd7;
    localparam logic [3:0] S_T_CHK  = 4'd8;
    localparam logic [3:0] S_H_ST   = 4'd9;
    localparam logic [3:0] S_H_MUL  = 4'd10;
    localparam logic [3:0] S_H_DS   = 4'd11;
    localparam logic [3:0] S_H_DIV  = 4'd12;
    localparam logic [3:0] S_H_TEX  = 4'd13;
    localparam logic [3:0] S_H_FIN  = 4'd14;
    localparam logic [3:0] S_OUT    = 4'd15;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = (i_mode == MODE_TRACE) ? S_T_INIT : S_W_WR;
                end
            end
            S_W_WR: begin
                if (i_sts.wr_in_grid) begin
                    o_cmd.vox_wr = 1'b1;
                    n_state = S_W_HCHK;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_W_HCHK: begin
                n_state = S_OUT;
                if (i_sts.solid_in) begin
                    o_cmd.col_wr_y = i_sts.h_lt_y;
                end else if (i_sts.h_ge_y) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = S_W_SRD;
                end
            end
            S_W_SRD: begin
                o_cmd.vox_rsel = VSEL_SCAN;
                n_state = S_W_SCHK;
            end
            S_W_SCHK: begin
                if (i_sts.scan_go && !i_sts.vox_q) begin
                    o_cmd.scan_dec = 1'b1;
                    n_state = S_W_SRD;
                end else begin
                    o_cmd.col_wr_h = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_T_INIT: begin
                o_cmd.trace_init = 1'b1;
                n_state = S_T_RD;
            end
            S_T_RD: begin
                o_cmd.vox_rsel = VSEL_TRACE;
                n_state = i_sts.cell_in_grid ? S_T_CHK : S_OUT;
            end
            S_T_CHK: begin
                if (i_sts.vox_q) begin
                    n_state = S_H_ST;
                end else if (i_sts.dir_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state = S_T_RD;
                end
            end
            S_H_ST: begin
                if (i_sts.has_last) begin
                    n_state = S_H_MUL;
                end else begin
                    o_cmd.origin_frac = 1'b1;
                    n_state = S_H_TEX;
                end
            end
            S_H_MUL: begin
                o_cmd.mul_ax = 1'b1;
                n_state = S_H_DS;
            end
            S_H_DS: begin
                if (!i_sts.div_busy) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_H_DIV;
                end
            end
            S_H_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.acc_ax = 1'b1;
                    n_state = i_sts.ax_last ? S_H_TEX : S_H_MUL;
                end
            end
            S_H_TEX: begin
                o_cmd.vox_rsel = VSEL_TEX;
                o_cmd.col_nb   = 1'b1;
                n_state = S_H_FIN;
            end
            S_H_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_s_tready)
        else $error("request taken during grid clear");
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state != S_IDLE))
        else $error("accepted request not started");
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_sts.div_busy)
        else $error("divider restarted while busy");
    a_step_nonzero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> !i_sts.dir_zero)
        else $error("ray step with zero direction");
`endif
endmodule

// ===== rtl/core/vrt_dp.sv =====
// Datapath: grid and height memories, ray stepping, hit point divider and shading.
`timescale 1ns / 1ps
module vrt_dp #(
    parameter int GRID_X = 16,
    parameter int GRID_Y = 16,
    parameter int GRID_Z = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    input  logic [vrt_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [vrt_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic [vrt_pkg::IN_TDATA_W-1:0]         i_s_tdata,
    input  vrt_pkg::t_cmd                          i_cmd,
    output vrt_pkg::t_sts                          o_sts,
    input  logic                                   i_m_tready,
    output logic                                   o_m_tvalid,
    output logic [vrt_pkg::OUT_TDATA_W-1:0]        o_m_tdata,
    output logic                                   o_m_tuser
);
    import vrt_pkg::*;

    localparam int XW   = $clog2(GRID_X);
    localparam int YW   = $clog2(GRID_Y);
    localparam int ZW   = $clog2(GRID_Z);
    localparam int NVOX = GRID_X * GRID_Y * GRID_Z;
    localparam int VA   = $clog2(NVOX);
    localparam int NCOL = GRID_X * GRID_Z;
    localparam int CA   = $clog2(NCOL);
    localparam int GMXY = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
    localparam int GMAX = (GMXY > GRID_Z) ? GMXY : GRID_Z;
    localparam int LG   = $clog2(GMAX);
    localparam int CW   = ((LG > COORD_W) ? LG : COORD_W) + 2;
    localparam int NW   = LG + 13;
    localparam int AW   = DIR_W;
    localparam int PW   = NW + AW;
    localparam int SW   = ((NW > 16) ? NW : 16) + 3;

    function automatic logic [VA-1:0] vaddr(input logic [XW-1:0] x, input logic [YW-1:0] y,
                                           input logic [ZW-1:0] z);
        vaddr = VA'((VA'(x) * VA'(GRID_Y) + VA'(y)) * VA'(GRID_Z) + VA'(z));
    endfunction

    function automatic logic [CA-1:0] caddr(input logic [XW-1:0] x, input logic [ZW-1:0] z);
        caddr = CA'(CA'(x) * CA'(GRID_Z) + CA'(z));
    endfunction

    function automatic logic in_axis(input logic signed [CW-1:0] c, input int g);
        in_axis = (c >= 0) && (c < $signed(CW'(g)));
    endfunction

    // configuration
    logic [15:0] r_org [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= ORIGIN_X_RST;
            r_org[1] <= ORIGIN_Y_RST;
            r_org[2] <= ORIGIN_Z_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ORIGIN_X: r_org[0] <= i_cfg_data;
                CFG_ORIGIN_Y: r_org[1] <= i_cfg_data;
                CFG_ORIGIN_Z: r_org[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request fields
    logic [COORD_W-1:0]      r_ix, r_iy, r_iz;
    logic                    r_solid;
    logic signed [DIR_W-1:0] r_dir [0:2];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_ix     <= i_s_tdata[3:0];
            r_iy     <= i_s_tdata[7:4];
            r_iz     <= i_s_tdata[11:8];
            r_solid  <= i_s_tdata[12];
            r_dir[0] <= $signed(i_s_tdata[28:13]);
            r_dir[1] <= $signed(i_s_tdata[44:29]);
            r_dir[2] <= $signed(i_s_tdata[60:45]);
        end
    end

    // clear counter
    logic [VA-1:0] r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + VA'(1);
        end
    end

    // ray state
    logic signed [CW-1:0] r_cell [0:2];
    logic [AW-1:0]        r_a [0:2];
    logic                 r_neg [0:2];
    logic [NW-1:0]        r_n [0:2];
    logic [PW-1:0]        r_p01, r_p02, r_p10, r_p12, r_p20, r_p21;
    logic [NW-1:0]        r_ncross;
    logic [1:0]           r_last;
    logic                 r_has_last;
    logic [2:0]           r_face;
    logic [1:0]           r_k;
    logic [PW-1:0]        r_prod;
    logic [FRAC_W-1:0]    r_frac [0:2];
    logic [YW-1:0]        r_h;

    logic [AW-1:0]        w_ai [0:2];
    logic [FRAC_W-1:0]    w_ni [0:2];
    logic                 w_le01, w_le02, w_le12;
    logic [1:0]           w_pick;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_ai[k] = r_dir[k][DIR_W-1] ? AW'(-r_dir[k]) : AW'(r_dir[k]);
            w_ni[k] = r_dir[k][DIR_W-1] ? {1'b0, r_org[k][11:0]}
                                        : FRAC_W'(13'd4096 - {1'b0, r_org[k][11:0]});
        end
        w_le01 = (r_a[0] == '0) ? (r_a[1] == '0) : ((r_a[1] == '0) || (r_p01 <= r_p10));
        w_le02 = (r_a[0] == '0) ? (r_a[2] == '0) : ((r_a[2] == '0) || (r_p02 <= r_p20));
        w_le12 = (r_a[1] == '0) ? (r_a[2] == '0) : ((r_a[2] == '0) || (r_p12 <= r_p21));
        if (w_le01 && w_le02) begin
            w_pick = 2'd0;
        end else if (w_le12) begin
            w_pick = 2'd1;
        end else begin
            w_pick = 2'd2;
        end
    end

    // divider
    logic [NW-1:0] w_quo;
    logic          w_rem_nz, w_div_busy, w_div_done;

    vrt_div #(.DENW(AW), .QUOW(NW)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.div_start),
        .i_num    (r_prod),
        .i_den    (r_a[r_last]),
        .o_busy   (w_div_busy),
        .o_done   (w_div_done),
        .o_quo    (w_quo),
        .o_rem_nz (w_rem_nz)
    );

    logic signed [SW-1:0] w_qa, w_qb, w_qs, w_p;
    logic [FRAC_W-1:0]    w_pc;

    always_comb begin
        w_qa = $signed({{(SW-NW){1'b0}}, w_quo});
        w_qb = w_qa + $signed({{(SW-1){1'b0}}, w_rem_nz});
        w_qs = r_neg[r_k] ? -w_qb : w_qa;
        w_p  = $signed({{(SW-16){1'b0}}, r_org[r_k]}) + w_qs
             - ($signed({{(SW-CW){r_cell[r_k][CW-1]}}, r_cell[r_k]}) <<< 12);
        if (w_p < 0) begin
            w_pc = '0;
        end else if (w_p > $signed(SW'(4096))) begin
            w_pc = FRAC_W'(4096);
        end else begin
            w_pc = w_p[FRAC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_last <= 1'b0;
        end else if (i_cmd.trace_init) begin
            r_has_last <= 1'b0;
        end else if (i_cmd.step) begin
            r_has_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.trace_init) begin
            for (int k = 0; k < 3; k++) begin
                r_cell[k] <= $signed({{(CW-4){1'b0}}, r_org[k][15:12]});
                r_a[k]    <= w_ai[k];
                r_neg[k]  <= r_dir[k][DIR_W-1];
                r_n[k]    <= NW'(w_ni[k]);
            end
            r_p01 <= PW'(w_ni[0] * w_ai[1]);
            r_p02 <= PW'(w_ni[0] * w_ai[2]);
            r_p10 <= PW'(w_ni[1] * w_ai[0]);
            r_p12 <= PW'(w_ni[1] * w_ai[2]);
            r_p20 <= PW'(w_ni[2] * w_ai[0]);
            r_p21 <= PW'(w_ni[2] * w_ai[1]);
            r_face <= NRM_YHI;
            r_k    <= 2'd0;
        end else if (i_cmd.step) begin
            r_cell[w_pick] <= r_neg[w_pick] ? r_cell[w_pick] - CW'(1)
                                            : r_cell[w_pick] + CW'(1);
            r_n[w_pick]    <= r_n[w_pick] + NW'(4096);
            r_ncross       <= r_n[w_pick];
            r_last         <= w_pick;
            r_face         <= {w_pick, r_neg[w_pick]};
            case (w_pick)
                2'd0: begin
                    r_p01 <= r_p01 + (PW'(r_a[1]) << 12);
                    r_p02 <= r_p02 + (PW'(r_a[2]) << 12);
                end
                2'd1: begin
                    r_p10 <= r_p10 + (PW'(r_a[0]) << 12);
                    r_p12 <= r_p12 + (PW'(r_a[2]) << 12);
                end
                default: begin
                    r_p20 <= r_p20 + (PW'(r_a[0]) << 12);
                    r_p21 <= r_p21 + (PW'(r_a[1]) << 12);
                end
            endcase
        end else if (i_cmd.origin_frac) begin
            for (int k = 0; k < 3; k++) begin
                r_frac[k] <= {1'b0, r_org[k][11:0]};
            end
        end else if (i_cmd.mul_ax) begin
            r_prod <= PW'(r_ncross * r_a[r_k]);
        end else if (i_cmd.acc_ax) begin
            r_frac[r_k] <= w_pc;
            r_k         <= r_k + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_h <= YW'(GRID_Y - 1);
        end else if (i_cmd.scan_dec) begin
            r_h <= r_h - YW'(1);
        end
    end

    // neighbors of the hit cell
    logic signed [CW-1:0] w_nbx, w_nbz, w_aby;
    logic                 w_nb_ok, w_above_ok, w_cell_ok;

    always_comb begin
        w_nbx = r_cell[0];
        w_nbz = r_cell[2];
        case (r_face)
            NRM_XLO: w_nbx = r_cell[0] - CW'(1);
            NRM_XHI: w_nbx = r_cell[0] + CW'(1);
            NRM_ZLO: w_nbz = r_cell[2] - CW'(1);
            NRM_ZHI: w_nbz = r_cell[2] + CW'(1);
            default: ;
        endcase
        w_aby      = r_cell[1] + CW'(1);
        w_nb_ok    = in_axis(w_nbx, GRID_X) && in_axis(w_nbz, GRID_Z);
        w_above_ok = r_cell[1] < $signed(CW'(GRID_Y - 1));
        w_cell_ok  = in_axis(r_cell[0], GRID_X) && in_axis(r_cell[1], GRID_Y)
                  && in_axis(r_cell[2], GRID_Z);
    end

    // memories
    logic          w_vwe, w_vwd, w_vq;
    logic [VA-1:0] w_vwa, w_vra;
    logic          w_cwe;
    logic [CA-1:0] w_cwa, w_cra;
    logic [YW-1:0] w_cwd, w_cq;

    always_comb begin
        w_vwe = i_cmd.clr_step || i_cmd.vox_wr;
        w_vwa = i_cmd.clr_step ? r_clr : vaddr(XW'(r_ix), YW'(r_iy), ZW'(r_iz));
        w_vwd = i_cmd.clr_step ? 1'b0 : r_solid;
        case (i_cmd.vox_rsel)
            VSEL_SCAN: w_vra = vaddr(XW'(r_ix), r_h, ZW'(r_iz));
            VSEL_TEX:  w_vra = vaddr(XW'(r_cell[0]), YW'(w_aby), ZW'(r_cell[2]));
            default:   w_vra = vaddr(XW'(r_cell[0]), YW'(r_cell[1]), ZW'(r_cell[2]));
        endcase
        w_cwe = (i_cmd.clr_step && ({1'b0, r_clr} < (VA+1)'(NCOL)))
             || i_cmd.col_wr_y || i_cmd.col_wr_h;
        w_cwa = i_cmd.clr_step ? CA'(r_clr) : caddr(XW'(r_ix), ZW'(r_iz));
        w_cwd = i_cmd.clr_step ? '0 : (i_cmd.col_wr_y ? YW'(r_iy) : r_h);
        w_cra = i_cmd.col_nb ? caddr(XW'(w_nbx), ZW'(w_nbz)) : caddr(XW'(r_ix), ZW'(r_iz));
    end

    vrt_ram #(.WIDTH(1), .DEPTH(NVOX)) u_vox_ram (
        .i_clk   (i_clk),
        .i_we    (w_vwe),
        .i_waddr (w_vwa),
        .i_wdata (w_vwd),
        .i_raddr (w_vra),
        .o_rdata (w_vq)
    );

    vrt_ram #(.WIDTH(YW), .DEPTH(NCOL)) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (w_cwe),
        .i_waddr (w_cwa),
        .i_wdata (w_cwd),
        .i_raddr (w_cra),
        .o_rdata (w_cq)
    );

    // texel, texture kind and shading
    logic [FRAC_W-1:0] w_u, w_v, w_vi;
    logic [15:0]       w_u15, w_v15;
    logic [1:0]        w_kind;
    logic              w_shaded;
    logic [1:0]        r_kind;
    logic              r_shaded, r_is_hit;
    logic [7:0]        r_texel;

    always_comb begin
        if (r_face == NRM_XLO || r_face == NRM_XHI) begin
            w_u = r_frac[2];
            w_v = r_frac[1];
        end else if (r_face == NRM_YLO || r_face == NRM_YHI) begin
            w_u = r_frac[0];
            w_v = r_frac[2];
        end else begin
            w_u = r_frac[0];
            w_v = r_frac[1];
        end
        w_vi  = FRAC_W'(13'd4096 - w_v);
        w_u15 = ({3'b0, w_u} << 4) - {3'b0, w_u};
        w_v15 = ({3'b0, w_vi} << 4) - {3'b0, w_vi};
        if (r_face == NRM_YLO || (w_above_ok && w_vq)) begin
            w_kind = KIND_DIRT;
        end else if (r_face == NRM_YHI) begin
            w_kind = KIND_GRASS_TOP;
        end else begin
            w_kind = KIND_GRASS_SIDE;
        end
        w_shaded = (w_nb_ok && ($signed({{(CW-YW){1'b0}}, w_cq}) > r_cell[1]))
                || r_face == NRM_XLO || r_face == NRM_ZLO;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_kind   <= w_kind;
            r_shaded <= w_shaded;
            r_texel  <= {w_u15[15:12], w_v15[15:12]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_hit <= 1'b0;
        end else if (i_cmd.load_item) begin
            r_is_hit <= 1'b0;
        end else if (i_cmd.fin) begin
            r_is_hit <= 1'b1;
        end
    end

    // result register
    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;
    logic                   r_m_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_m_user <= r_is_hit;
            r_m_data <= r_is_hit ? {6'b0, r_shaded, r_kind, r_texel, r_face,
                                    r_cell[2][3:0], r_cell[1][3:0], r_cell[0][3:0]}
                                 : '0;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    always_comb begin
        o_sts.clr_last     = (r_clr == VA'(NVOX - 1));
        o_sts.wr_in_grid   = ({3'b0, r_ix} < 7'(GRID_X)) && ({3'b0, r_iy} < 7'(GRID_Y))
                          && ({3'b0, r_iz} < 7'(GRID_Z));
        o_sts.solid_in     = r_solid;
        o_sts.vox_q        = w_vq;
        o_sts.h_lt_y       = w_cq < YW'(r_iy);
        o_sts.h_ge_y       = w_cq >= YW'(r_iy);
        o_sts.scan_go      = (r_h != '0);
        o_sts.cell_in_grid = w_cell_ok;
        o_sts.dir_zero     = (r_a[0] == '0) && (r_a[1] == '0) && (r_a[2] == '0);
        o_sts.has_last     = r_has_last;
        o_sts.div_busy     = w_div_busy;
        o_sts.div_done     = w_div_done;
        o_sts.ax_last      = (r_k == 2'd2);
        o_sts.out_free     = !r_m_valid || i_m_tready;
    end
endmodule

// ===== rtl/core/voxel_ray_traversal_shader.sv =====
// Top level of the voxel ray traversal shader.
//
//  channel | direction | signals                                   | carries
//  cfg     | in        | i_cfg_valid/o_cfg_ready, index, data      | origin registers
//  s       | in        | i_s_tvalid/o_s_tready, tdata, tuser       | write or trace request
//  m       | out       | o_m_tvalid/i_m_tready, tdata, tuser       | one result per request
//
// A write stores the voxel; a removal at or below the column top rescans the column by rows.
// A trace steps the ray cell by cell until it hits, leaves the grid or has zero direction;
// a hit after at least one step adds the hit point divisions, one per axis (one quotient bit per
// cycle), and the shading.
// After reset the grid is cleared one voxel per cycle.
// One request is in work at a time; the result register frees the input while it waits.
`timescale 1ns / 1ps
module voxel_ray_traversal_shader #(
    parameter int GRID_X = 16,
    parameter int GRID_Y = 16,
    parameter int GRID_Z = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vrt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vrt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // cell_x[3:0] cell_y[7:4] cell_z[11:8] block_solid[12] dir_x[28:13] dir_y[44:29]
    // dir_z[60:45], zero fill up to bit 63
    input  logic [vrt_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // mode[0]
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // hit_x[3:0] hit_y[7:4] hit_z[11:8] hit_face[14:12] texel_index[22:15]
    // texture_kind[24:23] shaded[25], zero fill up to bit 31
    output logic [vrt_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // hit[0]
    output logic                            o_m_tuser
);
    import vrt_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    vrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_mode     (i_s_tuser),
        .i_sts      (w_sts),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    vrt_dp #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );
endmodule
